>>> sv/iptl_pkg.sv
`timescale 1ns / 1ps

package iptl_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_BITS   = 32;
  localparam int DEPTH_W    = $clog2(KEY_BITS + 1);
  localparam int VAL_W      = 33;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t parent;
    idx_t right;
    idx_t left;
  } links_t;

  localparam int LINK_W = $bits(links_t);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_NOFREE  = 2'd2,
    ST_NOTFND  = 2'd3
  } status_t;

endpackage

>>> sv/iptl_node_ram.sv
`timescale 1ns / 1ps

module iptl_node_ram
  import iptl_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  idx_t               rd_addr,
  output links_t             rd_lnk,
  output logic [VAL_W-1:0]   rd_val,
  input  logic               lnk_we,
  input  idx_t               lnk_addr,
  input  links_t             lnk_wdata,
  input  logic               val_we,
  input  idx_t               val_addr,
  input  logic [VAL_W-1:0]   val_wdata
);

  links_t             lnk_mem [NODE_COUNT];
  logic [VAL_W-1:0]   val_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_addr] <= lnk_wdata;
    end
    if (val_we) begin
      val_mem[val_addr] <= val_wdata;
    end
    if (rd_en) begin
      rd_lnk <= lnk_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

>>> sv/ipv4_prefix_trie_lookup.sv
`timescale 1ns / 1ps
// Find reads the root, then one node per level, for at most 32 key bits.
// Insert and delete first count the prefix length, one mask bit a cycle, then
// walk one level per cycle; insert builds a node in S_AGET, S_ANEXT (on reuse),
// S_APAR and S_ANEW; delete prunes a node in S_PRD, S_PUPD and S_PFREE.
// One word is worked on at a time; the next is taken once the result is queued.
// Reset: synchronous, active low; after release S_INIT clears the root node.

module ipv4_prefix_trie_lookup
  import iptl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key, prefix_mask, entry_value
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // found, match_value, zero pad
  output logic [1:0]   out_tuser   // status
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LEN, S_IWALK, S_AGET, S_ANEXT, S_APAR, S_ANEW,
    S_DWALK, S_PRD, S_PUPD, S_PFREE, S_FIND, S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [31:0]       mask_r, mask_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [DEPTH_W-1:0] d_r, d_nxt;
  logic [DEPTH_W-1:0] len_r, len_nxt;
  idx_t              node_r, node_nxt;
  idx_t              new_r, new_nxt;
  links_t            cur_r, cur_nxt;
  links_t            plnk_r, plnk_nxt;
  logic              pval_r, pval_nxt;
  idx_t              free_head_r, free_head_nxt;
  logic [CNT_W-1:0]  list_cnt_r, list_cnt_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              res_found_r, res_found_nxt;
  logic [31:0]       res_match_r, res_match_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [31:0]       out_match_r, out_match_nxt;

  logic              rd_en;
  idx_t              rd_addr;
  links_t            rd_lnk;
  logic [VAL_W-1:0]  rd_val;
  logic              lnk_we;
  idx_t              lnk_addr;
  links_t            lnk_wdata;
  logic              val_we;
  idx_t              val_addr;
  logic [VAL_W-1:0]  val_wdata;

  logic [4:0]        bit_idx;
  logic              kbit;
  logic              mbit;
  idx_t              child;
  logic [CNT_W-1:0]  free_cnt;
  logic [CNT_W-1:0]  need;
  logic              last_lvl;
  links_t            upd;

  iptl_node_ram u_ram (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_lnk    (rd_lnk),
    .rd_val    (rd_val),
    .lnk_we    (lnk_we),
    .lnk_addr  (lnk_addr),
    .lnk_wdata (lnk_wdata),
    .val_we    (val_we),
    .val_addr  (val_addr),
    .val_wdata (val_wdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_match_r, out_found_r};
  assign out_tuser  = out_status_r;

  assign bit_idx  = 5'(6'(KEY_BITS - 1) - 6'(d_r));
  assign kbit     = key_r[bit_idx];
  assign mbit     = mask_r[bit_idx];
  assign child    = kbit ? rd_lnk.right : rd_lnk.left;
  assign free_cnt = list_cnt_r + (CNT_W'(NODE_COUNT) - fresh_r);
  assign need     = CNT_W'(len_r - d_r);
  assign last_lvl = ((d_r + 1'b1) == len_r);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    mask_nxt       = mask_r;
    val_nxt        = val_r;
    d_nxt          = d_r;
    len_nxt        = len_r;
    node_nxt       = node_r;
    new_nxt        = new_r;
    cur_nxt        = cur_r;
    plnk_nxt       = plnk_r;
    pval_nxt       = pval_r;
    free_head_nxt  = free_head_r;
    list_cnt_nxt   = list_cnt_r;
    fresh_nxt      = fresh_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_match_nxt  = res_match_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_match_nxt  = out_match_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    lnk_we         = 1'b0;
    lnk_addr       = '0;
    lnk_wdata      = '0;
    val_we         = 1'b0;
    val_addr       = '0;
    val_wdata      = '0;
    upd            = rd_lnk;

    case (state_r)
      S_INIT: begin
        lnk_we    = 1'b1;
        val_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt      = kind_t'(in_tuser);
          key_nxt       = in_tdata[31:0];
          mask_nxt      = in_tdata[63:32];
          val_nxt       = in_tdata[95:64];
          d_nxt         = '0;
          node_nxt      = '0;
          res_found_nxt = 1'b0;
          res_match_nxt = '0;
          case (kind_t'(in_tuser))
            KIND_INSERT, KIND_DELETE: state_nxt = S_LEN;
            KIND_FIND: begin
              rd_en     = 1'b1;
              state_nxt = S_FIND;
            end
            default: begin
              res_status_nxt = ST_NOTFND;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_LEN: begin
        if (d_r < DEPTH_W'(KEY_BITS) && mbit) begin
          d_nxt = d_r + 1'b1;
        end else begin
          len_nxt   = d_r;
          d_nxt     = '0;
          rd_en     = 1'b1;
          state_nxt = (kind_r == KIND_INSERT) ? S_IWALK : S_DWALK;
        end
      end
      S_IWALK: begin
        cur_nxt = rd_lnk;
        if (d_r < len_r) begin
          if (child != '0) begin
            node_nxt = child;
            d_nxt    = d_r + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = child;
          end else if (free_cnt < need) begin
            res_status_nxt = ST_NOFREE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_AGET;
          end
        end else begin
          if (rd_val[32]) begin
            res_status_nxt = ST_DUP;
          end else begin
            val_we         = 1'b1;
            val_addr       = node_r;
            val_wdata      = {1'b1, val_r};
            res_status_nxt = ST_OK;
          end
          state_nxt = S_RESP;
        end
      end
      S_AGET: begin
        if (list_cnt_r != '0) begin
          new_nxt   = free_head_r;
          rd_en     = 1'b1;
          rd_addr   = free_head_r;
          state_nxt = S_ANEXT;
        end else begin
          new_nxt   = fresh_r[IDX_W-1:0];
          fresh_nxt = fresh_r + 1'b1;
          state_nxt = S_APAR;
        end
      end
      S_ANEXT: begin
        if (list_cnt_r > CNT_W'(1)) begin
          free_head_nxt = rd_lnk.right;
        end
        list_cnt_nxt = list_cnt_r - 1'b1;
        state_nxt    = S_APAR;
      end
      S_APAR: begin
        lnk_we    = 1'b1;
        lnk_addr  = node_r;
        lnk_wdata = cur_r;
        if (kbit) begin
          lnk_wdata.right = new_r;
        end else begin
          lnk_wdata.left = new_r;
        end
        state_nxt = S_ANEW;
      end
      S_ANEW: begin
        lnk_we           = 1'b1;
        lnk_addr         = new_r;
        lnk_wdata        = '0;
        lnk_wdata.parent = node_r;
        val_we           = 1'b1;
        val_addr         = new_r;
        val_wdata        = last_lvl ? {1'b1, val_r} : '0;
        cur_nxt          = lnk_wdata;
        node_nxt         = new_r;
        d_nxt            = d_r + 1'b1;
        if (last_lvl) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_AGET;
        end
      end
      S_DWALK: begin
        if (d_r < len_r) begin
          if (child == '0) begin
            res_status_nxt = ST_NOTFND;
            state_nxt      = S_RESP;
          end else begin
            node_nxt = child;
            d_nxt    = d_r + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = child;
          end
        end else if (!rd_val[32]) begin
          res_status_nxt = ST_NOTFND;
          state_nxt      = S_RESP;
        end else begin
          val_we         = 1'b1;
          val_addr       = node_r;
          cur_nxt        = rd_lnk;
          res_status_nxt = ST_OK;
          if (node_r == '0 || rd_lnk.left != '0 || rd_lnk.right != '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PRD;
          end
        end
      end
      S_PRD: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r.parent;
        state_nxt = S_PUPD;
      end
      S_PUPD: begin
        if (rd_lnk.right == node_r) begin
          upd.right = '0;
        end else begin
          upd.left = '0;
        end
        lnk_we    = 1'b1;
        lnk_addr  = cur_r.parent;
        lnk_wdata = upd;
        plnk_nxt  = upd;
        pval_nxt  = rd_val[32];
        state_nxt = S_PFREE;
      end
      S_PFREE: begin
        lnk_we          = 1'b1;
        lnk_addr        = node_r;
        lnk_wdata       = cur_r;
        lnk_wdata.right = free_head_r;
        free_head_nxt   = node_r;
        list_cnt_nxt    = list_cnt_r + 1'b1;
        node_nxt        = cur_r.parent;
        cur_nxt         = plnk_r;
        if (cur_r.parent == '0 || plnk_r.left != '0 || plnk_r.right != '0 || pval_r) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_FIND: begin
        if (rd_val[32]) begin
          res_found_nxt = 1'b1;
          res_match_nxt = rd_val[31:0];
        end
        if (d_r >= DEPTH_W'(KEY_BITS) || child == '0) begin
          res_status_nxt = (rd_val[32] || res_found_r) ? ST_OK : ST_NOTFND;
          state_nxt      = S_RESP;
        end else begin
          node_nxt = child;
          d_nxt    = d_r + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = child;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_match_nxt  = res_match_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      free_head_r <= '0;
      list_cnt_r  <= '0;
      fresh_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      list_cnt_r  <= list_cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    mask_r       <= mask_nxt;
    val_r        <= val_nxt;
    d_r          <= d_nxt;
    len_r        <= len_nxt;
    node_r       <= node_nxt;
    new_r        <= new_nxt;
    cur_r        <= cur_nxt;
    plnk_r       <= plnk_nxt;
    pval_r       <= pval_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_match_r  <= res_match_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_match_r  <= out_match_nxt;
  end

  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r >= CNT_W'(1) && fresh_r <= CNT_W'(NODE_COUNT))
    else $error("fresh node pointer out of range");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt <= CNT_W'(NODE_COUNT - 1))
    else $error("free pool larger than node memory");

  a_new_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ANEW |-> new_r != '0)
    else $error("root handed out as new node");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("word accepted without starting work");

endmodule

>>> tb/sv/tb_ipv4_prefix_trie_lookup.sv
`timescale 1ns / 1ps

module tb_ipv4_prefix_trie_lookup;
  import iptl_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    status_t     status;
    logic        found;
    logic [31:0] match_value;
  } lpm_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;

  lpm_result_t pending_results[$];

  // predictor copy of the trie
  int unsigned tr_left[NODE_COUNT];
  int unsigned tr_right[NODE_COUNT];
  int unsigned tr_parent[NODE_COUNT];
  logic [32:0] tr_value[NODE_COUNT];
  int unsigned tr_free_head;
  int unsigned tr_fresh_next;
  int unsigned tr_free_count;

  // prefixes sent for insertion, for well-formed delete/find traffic
  logic [31:0] known_keys[$];
  logic [31:0] known_masks[$];

  always #2 clk = ~clk;

  ipv4_prefix_trie_lookup u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic int unsigned key_bit(logic [31:0] k, int unsigned d);
    return 32'(k[31-d]);
  endfunction

  function automatic int unsigned mask_len(logic [31:0] m);
    int unsigned d;
    d = 0;
    while (d < 32 && m[31-d]) d++;
    return d;
  endfunction

  function automatic int unsigned child_of(int unsigned n, int unsigned b);
    return b ? tr_right[n] : tr_left[n];
  endfunction

  function automatic void set_child(int unsigned n, int unsigned b, int unsigned c);
    if (b) tr_right[n] = c;
    else   tr_left[n] = c;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODE_COUNT; i++) begin
      tr_left[i] = 0;
      tr_right[i] = 0;
      tr_parent[i] = 0;
      tr_value[i] = '0;
    end
    tr_free_head = NODE_COUNT;
    tr_fresh_next = 1;
    tr_free_count = NODE_COUNT - 1;
  endfunction

  function automatic int unsigned take_node();
    int unsigned listed;
    int unsigned idx;
    listed = tr_free_count - (NODE_COUNT - tr_fresh_next);
    if (listed > 0 && tr_free_head < NODE_COUNT) begin
      idx = tr_free_head;
      tr_free_head = (listed > 1) ? tr_right[idx] : NODE_COUNT;
    end else begin
      idx = tr_fresh_next;
      tr_fresh_next++;
    end
    tr_free_count--;
    return idx % NODE_COUNT;
  endfunction

  function automatic status_t trie_insert(logic [31:0] k, logic [31:0] m, logic [31:0] v);
    int unsigned len, node, d, c, n;
    len = mask_len(m);
    node = 0;
    d = 0;
    while (d < len) begin
      c = child_of(node, key_bit(k, d));
      if (c == 0) break;
      node = c;
      d++;
    end
    if (d == len) begin
      if (tr_value[node][32]) return ST_DUP;
      tr_value[node] = {1'b1, v};
      return ST_OK;
    end
    if (tr_free_count < len - d) return ST_NOFREE;
    while (d < len) begin
      n = take_node();
      tr_left[n] = 0;
      tr_right[n] = 0;
      tr_parent[n] = node;
      tr_value[n] = '0;
      set_child(node, key_bit(k, d), n);
      node = n;
      d++;
    end
    tr_value[node] = {1'b1, v};
    return ST_OK;
  endfunction

  function automatic status_t trie_delete(logic [31:0] k, logic [31:0] m);
    int unsigned len, node, p;
    len = mask_len(m);
    node = 0;
    for (int unsigned d = 0; d < len; d++) begin
      node = child_of(node, key_bit(k, d));
      if (node == 0) return ST_NOTFND;
    end
    if (!tr_value[node][32]) return ST_NOTFND;
    tr_value[node] = '0;
    if (node == 0 || tr_left[node] != 0 || tr_right[node] != 0) return ST_OK;
    forever begin
      p = tr_parent[node];
      if (tr_right[p] == node) tr_right[p] = 0;
      else tr_left[p] = 0;
      tr_right[node] = tr_free_head;
      tr_free_head = node;
      tr_free_count++;
      node = p;
      if (node == 0 || tr_left[node] != 0 || tr_right[node] != 0) break;
      if (tr_value[node][32]) break;
    end
    return ST_OK;
  endfunction

  function automatic lpm_result_t predict_lookup(kind_t kind, logic [31:0] k,
                                                 logic [31:0] m, logic [31:0] v);
    lpm_result_t r;
    int unsigned node, d;
    r.status = ST_NOTFND;
    r.found = 1'b0;
    r.match_value = '0;
    case (kind)
      KIND_INSERT: r.status = trie_insert(k, m, v);
      KIND_DELETE: r.status = trie_delete(k, m);
      KIND_FIND: begin
        node = 0;
        d = 0;
        forever begin
          if (tr_value[node][32]) begin
            r.found = 1'b1;
            r.match_value = tr_value[node][31:0];
          end
          if (d >= 32) break;
          node = child_of(node, key_bit(k, d));
          if (node == 0) break;
          d++;
        end
        r.status = r.found ? ST_OK : ST_NOTFND;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(kind_t kind, logic [31:0] k, logic [31:0] m, logic [31:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {v, m, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_lookup(kind, k, m, v));
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lpm_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_tuser);
          error_count++;
        end
        if (out_tdata[0] !== exp_r.found) begin
          $error("found expected %0d actual %0d", exp_r.found, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[32:1] !== exp_r.match_value) begin
          $error("match_value expected %h actual %h", exp_r.match_value, out_tdata[32:1]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] len_to_mask(int unsigned len);
    return (len == 0) ? 32'd0 : ~(32'hFFFF_FFFF >> len);
  endfunction

  task automatic test_directed();
    send_word(KIND_FIND, 32'h0, 32'h0, 32'h0);
    send_word(KIND_DELETE, 32'h0, 32'h0, 32'h0);
    send_word(KIND_INSERT, 32'h0, 32'h0, 32'h1111_1111);
    send_word(KIND_INSERT, 32'h0, 32'h0, 32'h2222_2222);
    send_word(KIND_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(KIND_INSERT, 32'hC0A8_0000, 32'hFFFF_0000, 32'hAAAA_5555);
    send_word(KIND_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h5555_AAAA);
    send_word(KIND_INSERT, 32'hC0A8_0100, 32'hFFFF_FF0F, 32'h0);
    send_word(KIND_FIND, 32'hC0A8_0105, 32'h0, 32'h0);
    send_word(KIND_FIND, 32'hC0A8_0205, 32'h0, 32'h0);
    send_word(KIND_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(KIND_FIND, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_DELETE, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0);
    send_word(KIND_DELETE, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0);
    send_word(KIND_DELETE, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0);
    send_word(KIND_FIND, 32'hC0A8_0105, 32'h0, 32'h0);
    send_word(KIND_DELETE, 32'h1234_0000, 32'hFFF0_0000, 32'h0);
    send_word(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_word(KIND_DELETE, 32'h0, 32'h0, 32'h0);
    send_word(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_FIND, 32'h0, 32'h0, 32'h0);
  endtask

  // exhaust the pool with long disjoint prefixes, then hit the no-free case
  task automatic test_pool_exhaustion();
    logic [31:0] k;
    int unsigned n;
    n = 0;
    while (tr_free_count >= 32) begin
      k = {n[11:0], 20'h0};
      send_word(KIND_INSERT, k, 32'hFFFF_FFFF, n);
      known_keys.push_back(k);
      known_masks.push_back(32'hFFFF_FFFF);
      n++;
    end
    send_word(KIND_INSERT, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h1);
    send_word(KIND_INSERT, {n[11:0], 20'h0}, 32'hFFFF_FFFF, 32'h2);
    while (known_keys.size() > 0) begin
      send_word(KIND_DELETE, known_keys.pop_front(), known_masks.pop_front(), 32'h0);
    end
    send_word(KIND_FIND, 32'h0000_0000, 32'h0, 32'h0);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned sel, len, idx;
    logic [31:0] k, m;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(32) : $urandom_range(12);
      k = $urandom();
      if ($urandom_range(1)) k[31:24] = 8'h0A;
      m = len_to_mask(len);
      if ($urandom_range(3) == 0) m = $urandom();
      else if (len < 32) m = m | ($urandom() >> (len + 1));
      if (sel < 35) begin
        send_word(KIND_INSERT, k, m, $urandom());
        known_keys.push_back(k);
        known_masks.push_back(m);
      end else if (sel < 55 && known_keys.size() > 0) begin
        idx = $urandom_range(known_keys.size() - 1);
        send_word(KIND_DELETE, known_keys[idx], known_masks[idx], $urandom());
        known_keys.delete(idx);
        known_masks.delete(idx);
      end else if (sel < 65) begin
        send_word(KIND_DELETE, k, m, $urandom());
      end else if (sel < 95) begin
        if (known_keys.size() > 0 && $urandom_range(1)) begin
          idx = $urandom_range(known_keys.size() - 1);
          k = known_keys[idx] ^ ($urandom() >> mask_len(known_masks[idx]));
        end
        send_word(KIND_FIND, k, $urandom(), $urandom());
      end else begin
        send_word(KIND_NONE, k, m, $urandom());
      end
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(40);
    send_idle_pct = 84; recv_stall_pct = 0;  test_random(35);
    send_idle_pct = 0;  recv_stall_pct = 84; test_random(35);
    send_idle_pct = 31; recv_stall_pct = 31; test_random(40);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    trie_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_exhaustion();
    test_idle_phases();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/iptl_pkg.sv
sv/iptl_node_ram.sv
sv/ipv4_prefix_trie_lookup.sv
tb/sv/tb_ipv4_prefix_trie_lookup.sv
